/* sv/iqs_pkg.sv */
// Shared request and result types for the iterative quicksort unit.
`default_nettype none

package iqs_pkg;

    localparam int OUT_BITS = 32;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] value;
        logic                       is_last;
    } item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sorted_value;
        logic                       end_of_set;
        logic                       overflow;
    } result_t;

endpackage

`default_nettype wire

/* sv/iterative_quicksort_unit.sv */
// Iterative quicksort unit: element memory, range queue memory and sort sequencer.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+-------------------------------------
//   item    | in  | item_valid / item_ready     | value, is_last
//   result  | out | result_valid / result_ready | sorted_value, end_of_set, overflow
//
// Loading accepts one request per cycle while item_ready is high. Per partitioned
// range the sort reads the pivot, reads and compares each element, swaps where
// needed, places the pivot, queues the subranges and fetches the next range; its
// pace is bound by the single element write port. Emission reads each result and
// loads it into the output register. item_ready is low from the last request until
// the final result is loaded into the output register; a stalled result holds emission.
// Reset clears control state only; the memories need no clearing pass.
`default_nettype none

module iterative_quicksort_unit #(
    parameter int MAX_ELEMENTS = 64,
    parameter int VALUE_WIDTH  = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire iqs_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output iqs_pkg::result_t      result
);

    localparam int IW    = $clog2(MAX_ELEMENTS);
    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int QW    = 2 * CW;
    localparam int VW    = VALUE_WIDTH;
    localparam int EXT_W = iqs_pkg::OUT_BITS + VALUE_WIDTH;
    localparam logic [CW-1:0] MAX_C    = CW'(MAX_ELEMENTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ELEMENTS - 1);

    typedef enum logic [3:0] {
        S_LOAD, S_RANGE, S_PIV, S_RD, S_CMP, S_SWP, S_FIN, S_FIN_LO, S_FIN_PV,
        S_PUSH_L, S_PUSH_R, S_POP, S_POP_W, S_EMIT_RD, S_EMIT_LD
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [IW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     bound_reg, bound_next;
    logic [VW-1:0]     pivot_reg, pivot_next;
    logic [CW-1:0]     emit_reg, emit_next;
    logic              result_valid_reg, result_valid_next;
    iqs_pkg::result_t  result_reg, result_next;

    logic [VW-1:0]     store_mem [MAX_ELEMENTS];
    logic              st_we, st_re;
    logic [IW-1:0]     st_wa, st_ra_a, st_ra_b;
    logic [VW-1:0]     st_wd;
    logic [VW-1:0]     st_a_reg, st_b_reg;

    logic [QW-1:0]     queue_mem [MAX_ELEMENTS];
    logic              q_we, q_re;
    logic [QW-1:0]     q_wd;
    logic [QW-1:0]     q_rd_reg;

    logic [CW-1:0]     mid, k_inc, bound_inc, emit_inc, count_after, fill_after;
    logic [EXT_W-1:0]  in_ext, out_ext;
    logic              less, result_free, right_push;

    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign k_inc     = k_reg + CW'(1);
    assign bound_inc = bound_reg + CW'(1);
    assign emit_inc  = emit_reg + CW'(1);
    assign in_ext    = EXT_W'($unsigned(item.value));
    assign out_ext   = EXT_W'(st_a_reg);
    assign less      = $signed(st_a_reg) < $signed(pivot_reg);
    assign result_free = !result_valid_reg || result_ready;
    assign right_push  = ({1'b0, hi_reg} > ({1'b0, bound_reg} + (CW+1)'(2)));

    assign item_ready   = (state_reg == S_LOAD);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        dropped_next      = dropped_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        fill_next         = fill_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        k_next            = k_reg;
        bound_next        = bound_reg;
        pivot_next        = pivot_reg;
        emit_next         = emit_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        count_after       = count_reg;
        fill_after        = fill_reg;
        st_we   = 1'b0;
        st_wa   = '0;
        st_wd   = '0;
        st_re   = 1'b0;
        st_ra_a = '0;
        st_ra_b = '0;
        q_we    = 1'b0;
        q_wd    = '0;
        q_re    = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (item_valid)
                begin
                    if (count_reg < MAX_C)
                    begin
                        st_we       = 1'b1;
                        st_wa       = count_reg[IW-1:0];
                        st_wd       = in_ext[VW-1:0];
                        count_after = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    count_next = count_after;
                    if (item.is_last)
                    begin
                        lo_next    = '0;
                        hi_next    = count_after;
                        state_next = S_RANGE;
                    end
                end
            end
            S_RANGE:
            begin
                st_re      = 1'b1;
                st_ra_a    = mid[IW-1:0];
                st_ra_b    = lo_reg[IW-1:0];
                bound_next = lo_reg;
                k_next     = lo_reg + CW'(1);
                state_next = S_PIV;
            end
            S_PIV:
            begin
                pivot_next = st_a_reg;
                st_we      = 1'b1;
                st_wa      = mid[IW-1:0];
                st_wd      = st_b_reg;
                state_next = (k_reg < hi_reg) ? S_RD : S_FIN;
            end
            S_RD:
            begin
                st_re      = 1'b1;
                st_ra_a    = k_reg[IW-1:0];
                st_ra_b    = bound_inc[IW-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (less)
                begin
                    st_we      = 1'b1;
                    st_wa      = bound_inc[IW-1:0];
                    st_wd      = st_a_reg;
                    bound_next = bound_inc;
                    state_next = S_SWP;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = (k_inc < hi_reg) ? S_RD : S_FIN;
                end
            end
            S_SWP:
            begin
                st_we      = 1'b1;
                st_wa      = k_reg[IW-1:0];
                st_wd      = st_b_reg;
                k_next     = k_inc;
                state_next = (k_inc < hi_reg) ? S_RD : S_FIN;
            end
            S_FIN:
            begin
                if (bound_reg == lo_reg)
                begin
                    st_we      = 1'b1;
                    st_wa      = lo_reg[IW-1:0];
                    st_wd      = pivot_reg;
                    state_next = S_PUSH_L;
                end
                else
                begin
                    st_re      = 1'b1;
                    st_ra_b    = bound_reg[IW-1:0];
                    state_next = S_FIN_LO;
                end
            end
            S_FIN_LO:
            begin
                st_we      = 1'b1;
                st_wa      = lo_reg[IW-1:0];
                st_wd      = st_b_reg;
                state_next = S_FIN_PV;
            end
            S_FIN_PV:
            begin
                st_we      = 1'b1;
                st_wa      = bound_reg[IW-1:0];
                st_wd      = pivot_reg;
                state_next = S_PUSH_L;
            end
            S_PUSH_L:
            begin
                // single-element ranges are already in place
                if ((bound_reg - lo_reg) >= CW'(2) && fill_reg < MAX_C)
                begin
                    q_we      = 1'b1;
                    q_wd      = {lo_reg, bound_reg};
                    tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
                    fill_next = fill_reg + CW'(1);
                end
                state_next = S_PUSH_R;
            end
            S_PUSH_R:
            begin
                if (right_push && fill_reg < MAX_C)
                begin
                    q_we       = 1'b1;
                    q_wd       = {bound_inc, hi_reg};
                    tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + IW'(1);
                    fill_after = fill_reg + CW'(1);
                end
                fill_next  = fill_after;
                emit_next  = '0;
                state_next = (fill_after != '0) ? S_POP : S_EMIT_RD;
            end
            S_POP:
            begin
                q_re       = 1'b1;
                head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IW'(1);
                fill_next  = fill_reg - CW'(1);
                state_next = S_POP_W;
            end
            S_POP_W:
            begin
                lo_next    = q_rd_reg[QW-1:CW];
                hi_next    = q_rd_reg[CW-1:0];
                state_next = S_RANGE;
            end
            S_EMIT_RD:
            begin
                st_re      = 1'b1;
                st_ra_a    = emit_reg[IW-1:0];
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (result_free)
                begin
                    result_valid_next        = 1'b1;
                    result_next.sorted_value = out_ext[iqs_pkg::OUT_BITS-1:0];
                    result_next.end_of_set   = (emit_inc == count_reg);
                    result_next.overflow     = dropped_reg;
                    emit_next                = emit_inc;
                    if (emit_inc == count_reg)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        head_next    = '0;
                        tail_next    = '0;
                        fill_next    = '0;
                        state_next   = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            dropped_reg      <= 1'b0;
            head_reg         <= '0;
            tail_reg         <= '0;
            fill_reg         <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            k_reg            <= '0;
            bound_reg        <= '0;
            pivot_reg        <= '0;
            emit_reg         <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            dropped_reg      <= dropped_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            fill_reg         <= fill_next;
            lo_reg           <= lo_next;
            hi_reg           <= hi_next;
            k_reg            <= k_next;
            bound_reg        <= bound_next;
            pivot_reg        <= pivot_next;
            emit_reg         <= emit_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_wa] <= st_wd;
        end
        if (st_re)
        begin
            st_a_reg <= store_mem[st_ra_a];
            st_b_reg <= store_mem[st_ra_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[tail_reg] <= q_wd;
        end
        if (q_re)
        begin
            q_rd_reg <= queue_mem[head_reg];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= MAX_C)
        else $error("range queue fill exceeds depth");

    a_range_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RANGE) |-> (lo_reg < hi_reg && hi_reg <= count_reg))
        else $error("popped range out of bounds");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (bound_reg < k_reg && k_reg < hi_reg))
        else $error("partition indices out of order");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (fill_reg == '0))
        else $error("range queue not empty while loading");

    a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD && result_free && emit_inc == count_reg)
        |=> (count_reg == '0 && !dropped_reg && state_reg == S_LOAD))
        else $error("set state not cleared after final result");

endmodule

`default_nettype wire

/* test/iqs_checker.sv */
// Checker for the iterative quicksort unit: predicts sorted output and compares results.
module iqs_checker
    import iqs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_ready,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result,
    output int      failures,
    output int      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 64;

    typedef struct {
        int lo;
        int hi;
    } span_t;

    logic signed [OUT_BITS-1:0] element_copy [CAPACITY];
    int                         stored;
    bit                         dropped;
    result_t                    sorted_due [$];

    function automatic void swap_pair(int a, int b);
        logic signed [OUT_BITS-1:0] t;
        t = element_copy[a];
        element_copy[a] = element_copy[b];
        element_copy[b] = t;
    endfunction

    // middle element becomes the pivot; smaller elements move forward
    function automatic int split_span(int lo, int hi);
        int mark;
        mark = lo;
        swap_pair(lo, lo + (hi - lo) / 2);
        for (int k = lo + 1; k < hi; k++)
        begin
            if (element_copy[k] < element_copy[lo])
            begin
                mark++;
                swap_pair(mark, k);
            end
        end
        swap_pair(lo, mark);
        return mark;
    endfunction

    function automatic void sort_and_queue();
        span_t spans [$];
        span_t s;
        int    p;
        spans.push_back('{0, stored});
        while (spans.size() != 0)
        begin
            s = spans.pop_front();
            p = split_span(s.lo, s.hi);
            if (p != s.lo)
                spans.push_back('{s.lo, p});
            if (p + 1 != s.hi)
                spans.push_back('{p + 1, s.hi});
        end
        for (int i = 0; i < stored; i++)
            sorted_due.push_back('{sorted_value: element_copy[i],
                                   end_of_set: (i == stored - 1),
                                   overflow: dropped});
        stored = 0;
        dropped = 1'b0;
    endfunction

    function automatic void check_result(result_t got);
        result_t want;
        if (sorted_due.size() == 0)
        begin
            $error("result with none outstanding: sorted_value %0d", got.sorted_value);
            failures++;
            return;
        end
        want = sorted_due.pop_front();
        if (got.sorted_value !== want.sorted_value)
        begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value, got.sorted_value);
            failures++;
        end
        if (got.end_of_set !== want.end_of_set)
        begin
            $error("end_of_set: expected %0b, got %0b", want.end_of_set, got.end_of_set);
            failures++;
        end
        if (got.overflow !== want.overflow)
        begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored = 0;
            dropped = 1'b0;
            sorted_due.delete();
            failures = 0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_result(result);
            if (item_valid && item_ready)
            begin
                if (stored < CAPACITY)
                begin
                    element_copy[stored] = item.value;
                    stored++;
                end
                else
                begin
                    dropped = 1'b1;
                end
                if (item.is_last)
                    sort_and_queue();
            end
        end
        outstanding = sorted_due.size();
    end

endmodule

/* test/tb_iterative_quicksort_unit.sv */
// Testbench top for the iterative quicksort unit: stimulus, watchdog and verdict.
module tb_iterative_quicksort_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import iqs_pkg::*;

    localparam int STALL_LIMIT  = 50000;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 130;
    localparam int DRAIN_CYCLES = 40;
    localparam int CAPACITY     = 64;

    localparam int PATTERN_RANDOM  = 0;
    localparam int PATTERN_RISING  = 1;
    localparam int PATTERN_FALLING = 2;
    localparam int PATTERN_FLAT    = 3;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    int      failures;
    int      outstanding;
    int      idle_cycles;
    bit      steady_in;
    bit      steady_out;

    always #5 clk = ~clk;

    iterative_quicksort_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    iqs_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            5, 6:    return $signed($urandom_range(0, 8)) - 4;
            7:       return 32'sh8000_0000;
            8:       return 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic signed [OUT_BITS-1:0] v, input logic last);
        int gap;
        gap = pick_gap(steady_in);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{value: v, is_last: last};
        do @(posedge clk); while (!(item_valid && item_ready));
    endtask

    task automatic send_set(input int size, input int pattern);
        logic signed [OUT_BITS-1:0] base;
        logic signed [OUT_BITS-1:0] v;
        int                         step;
        base = pick_value();
        step = $urandom_range(1, 1000);
        steady_in = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < size; i++)
        begin
            case (pattern)
                PATTERN_RISING:  v = base + i * step;
                PATTERN_FALLING: v = base - i * step;
                PATTERN_FLAT:    v = base;
                default:         v = pick_value();
            endcase
            send_item(v, i == size - 1);
        end
    endtask

    // receiver: random stalls, one long hold while the sender keeps offering
    initial
    begin
        int gap;
        int taken;
        bit held;
        taken = 0;
        held = 1'b0;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 16 == 0)
                steady_out = ($urandom_range(0, 3) == 0);
            if (!held && taken == 40)
            begin
                gap = LONG_HOLD;
                held = 1'b1;
            end
            else
            begin
                gap = pick_gap(steady_out);
            end
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_iterative_quicksort_unit: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int sent;
        int set_no;
        int size;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        steady_in = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single element, extremes, equal values, sorted and reversed runs
        send_item(32'sh8000_0000, 1'b1);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh0000_0000, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sh0000_0001, 1'b1);
        send_set(4, PATTERN_FLAT);
        send_set(5, PATTERN_RISING);
        send_set(5, PATTERN_FALLING);

        // random sets, one full and one past capacity
        sent = 0;
        set_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (set_no == 1)
                size = CAPACITY;
            else if (set_no == 3)
                size = CAPACITY + $urandom_range(1, 4);
            else
                size = $urandom_range(1, 12);
            send_set(size, $urandom_range(0, 5) > 3 ? $urandom_range(1, 3) : PATTERN_RANDOM);
            sent += size;
            set_no++;
        end

        item_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("tb_iterative_quicksort_unit: clean");
        else
            $display("tb_iterative_quicksort_unit: errors");
        $finish;
    end

endmodule

/* sim.f */
sv/iqs_pkg.sv
sv/iterative_quicksort_unit.sv
test/iqs_checker.sv
test/tb_iterative_quicksort_unit.sv
